// File: design/tetra_plane_split_unit_assert.svh
// assertion macros for the tetrahedron plane split unit
`ifndef TETRA_PLANE_SPLIT_UNIT_ASSERT_SVH
`define TETRA_PLANE_SPLIT_UNIT_ASSERT_SVH
// property that must hold every cycle outside reset
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// non-overlapping implication
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/tps_pkg.sv
// ---------------------------------------------------------------------------
// tps_pkg
// shared types, constants and piece tables of the plane split unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;
  localparam int FracBitsDefault = 16;
  localparam int CoordW = 32;
  localparam int SideW = 66;

  typedef enum logic [2:0] {
    REG_PX = 3'd0, REG_PY = 3'd1, REG_PZ = 3'd2,
    REG_NX = 3'd3, REG_NY = 3'd4, REG_NZ = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [4:0] p0;
    logic [4:0] p1;
    logic [4:0] p2;
    logic [4:0] p3;
    logic       side;
  } piece_row_t;

  // point codes: 0..3 positive list, 4..7 negative list, 8+4p+n cut point
  function automatic piece_row_t piece_row(input logic [3:0] r);
    piece_row_t t;
    case (r)
      4'd0:  t = '{5'd4, 5'd5, 5'd6, 5'd7, 1'b0};
      4'd1:  t = '{5'd0, 5'd8, 5'd9, 5'd10, 1'b1};
      4'd2:  t = '{5'd4, 5'd8, 5'd9, 5'd10, 1'b0};
      4'd3:  t = '{5'd4, 5'd5, 5'd9, 5'd10, 1'b0};
      4'd4:  t = '{5'd4, 5'd5, 5'd6, 5'd10, 1'b0};
      4'd5:  t = '{5'd0, 5'd1, 5'd8, 5'd9, 1'b1};
      4'd6:  t = '{5'd1, 5'd8, 5'd13, 5'd9, 1'b1};
      4'd7:  t = '{5'd1, 5'd13, 5'd12, 5'd8, 1'b1};
      4'd8:  t = '{5'd4, 5'd5, 5'd8, 5'd12, 1'b0};
      4'd9:  t = '{5'd5, 5'd13, 5'd8, 5'd12, 1'b0};
      4'd10: t = '{5'd5, 5'd13, 5'd9, 5'd8, 1'b0};
      4'd11: t = '{5'd0, 5'd8, 5'd12, 5'd16, 1'b1};
      4'd12: t = '{5'd0, 5'd1, 5'd12, 5'd16, 1'b1};
      4'd13: t = '{5'd0, 5'd1, 5'd2, 5'd16, 1'b1};
      4'd14: t = '{5'd4, 5'd8, 5'd12, 5'd16, 1'b0};
      default: t = '{5'd0, 5'd1, 5'd2, 5'd3, 1'b1};
    endcase
    return t;
  endfunction

  function automatic logic [3:0] case_start(input logic [2:0] pc);
    logic [3:0] r;
    case (pc)
      3'd0: r = 4'd0;
      3'd1: r = 4'd1;
      3'd2: r = 4'd5;
      3'd3: r = 4'd11;
      default: r = 4'd15;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] case_count(input logic [2:0] pc);
    logic [2:0] r;
    case (pc)
      3'd1, 3'd3: r = 3'd4;
      3'd2: r = 3'd6;
      default: r = 3'd1;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: design/tps_side_lane.sv
// ---------------------------------------------------------------------------
// tps_side_lane
// signed plane distance of one vertex, three products then a sum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tps_side_lane (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [tps_pkg::CoordW-1:0] vx,
  input  wire logic signed [tps_pkg::CoordW-1:0] vy,
  input  wire logic signed [tps_pkg::CoordW-1:0] vz,
  input  wire logic signed [tps_pkg::CoordW-1:0] px,
  input  wire logic signed [tps_pkg::CoordW-1:0] py,
  input  wire logic signed [tps_pkg::CoordW-1:0] pz,
  input  wire logic signed [tps_pkg::CoordW-1:0] nx,
  input  wire logic signed [tps_pkg::CoordW-1:0] ny,
  input  wire logic signed [tps_pkg::CoordW-1:0] nz,
  output logic signed [tps_pkg::SideW-1:0]       side
);
  logic signed [tps_pkg::CoordW:0] dx, dy, dz;
  logic signed [64:0] mx, my, mz;

  assign dx = 33'(vx) - 33'(px);
  assign dy = 33'(vy) - 33'(py);
  assign dz = 33'(vz) - 33'(pz);

  always_ff @(posedge clk) begin
    if (en) begin
      mx <= 65'(dx) * 65'(nx);
      my <= 65'(dy) * 65'(ny);
      mz <= 65'(dz) * 65'(nz);
    end
  end

  assign side = 66'(mx) + 66'(my) + 66'(mz);
endmodule
`default_nettype wire

// File: design/tps_cut_lane.sv
// ---------------------------------------------------------------------------
// tps_cut_lane
// one edge cut: restoring divide for t then scaled offset per axis
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tps_cut_lane #(
  parameter int FracBits = tps_pkg::FracBitsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              start,
  input  wire logic                              run,
  input  wire logic [tps_pkg::SideW-1:0]         num,
  input  wire logic [tps_pkg::SideW-1:0]         den,
  input  wire logic signed [tps_pkg::CoordW-1:0] ax,
  input  wire logic signed [tps_pkg::CoordW-1:0] ay,
  input  wire logic signed [tps_pkg::CoordW-1:0] az,
  input  wire logic signed [tps_pkg::CoordW-1:0] bx,
  input  wire logic signed [tps_pkg::CoordW-1:0] by,
  input  wire logic signed [tps_pkg::CoordW-1:0] bz,
  output logic signed [tps_pkg::CoordW-1:0]      cx,
  output logic signed [tps_pkg::CoordW-1:0]      cy,
  output logic signed [tps_pkg::CoordW-1:0]      cz
);
  localparam int RemW = tps_pkg::SideW + 1;
  localparam int QW = FracBits + 1;

  // one quotient bit per start/run cycle; num <= den, first is bit FracBits
  logic [RemW-1:0] rem;
  logic [tps_pkg::SideW-1:0] dv;
  logic [QW-1:0] q;
  logic signed [tps_pkg::CoordW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic [RemW-1:0] rem_in, rem_sh;
  logic bit_q;

  assign rem_in = start ? RemW'(num) : {rem[RemW-2:0], 1'b0};
  assign bit_q = rem_in >= RemW'(start ? den : dv);
  assign rem_sh = bit_q ? rem_in - RemW'(start ? den : dv) : rem_in;

  always_ff @(posedge clk) begin
    // quotient holds once all bits are in
    if (start || run) begin
      rem <= rem_sh;
      q <= {q[QW-2:0], bit_q};
    end
    if (start) begin
      dv <= den;
      a_x <= ax; a_y <= ay; a_z <= az;
      b_x <= bx; b_y <= by; b_z <= bz;
    end
  end

  function automatic logic signed [tps_pkg::CoordW-1:0] cut_axis(
    input logic signed [tps_pkg::CoordW-1:0] a,
    input logic signed [tps_pkg::CoordW-1:0] b,
    input logic [QW-1:0] t
  );
    logic signed [tps_pkg::CoordW:0] d;
    logic [tps_pkg::CoordW:0] m;
    logic [tps_pkg::CoordW+QW:0] p;
    logic [tps_pkg::CoordW:0] s;
    d = 33'(b) - 33'(a);
    m = d[tps_pkg::CoordW] ? 33'(-d) : 33'(d);
    p = (tps_pkg::CoordW+QW+1)'(t) * (tps_pkg::CoordW+QW+1)'(m);
    s = 33'(p >> FracBits);
    if (d[tps_pkg::CoordW]) s = -s;
    return tps_pkg::CoordW'(33'(a) + s);
  endfunction

  assign cx = cut_axis(a_x, b_x, q);
  assign cy = cut_axis(a_y, b_y, q);
  assign cz = cut_axis(a_z, b_z, q);
endmodule
`default_nettype wire

// File: design/tetra_plane_split_unit.sv
// ---------------------------------------------------------------------------
// tetra_plane_split_unit
// splits a tetrahedron by a plane and streams the pieces vertex by vertex
// ---------------------------------------------------------------------------
//  channel | signals                          | dir
//  in      | in_valid/in_ready, v0_x..v3_z    | sink
//  out     | out_valid/out_ready, out_x..last | source
//  cfg     | cfg_we, cfg_index, cfg_data      | sink
// an item needs 4 beats per piece on the single vertex output, so a six-piece
// item gives 24 beats; the sequencer is loaded from the dividers first.
// after the accept the side products are registered, the dividers iterate,
// the sequencer loads and the first beat is registered. no new item is taken
// until the held one leaves the dividers, which waits for a free sequencer.
// reset restores the plane registers and empties the pipeline.
// a stalled out_ready holds the current beat and freezes emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tetra_plane_split_unit #(
  parameter int FracBits = tps_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] v0_x, v0_y, v0_z,
  input  wire logic signed [31:0] v1_x, v1_y, v1_z,
  input  wire logic signed [31:0] v2_x, v2_y, v2_z,
  input  wire logic signed [31:0] v3_x, v3_y, v3_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_x, out_y, out_z,
  output logic             piece_side,
  output logic [2:0]       positive_count,
  output logic             piece_end,
  output logic             last
);
  localparam int CW = tps_pkg::CoordW;
  localparam int SW = tps_pkg::SideW;
  localparam int Lat = FracBits + 1;
  localparam int CntW = $clog2(Lat + 2);

  logic signed [CW-1:0] px, py, pz, nx, ny, nz;
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0; py <= '0; pz <= '0;
      nx <= CW'(65536); ny <= '0; nz <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tps_pkg::REG_PX: px <= cfg_data;
        tps_pkg::REG_PY: py <= cfg_data;
        tps_pkg::REG_PZ: pz <= cfg_data;
        tps_pkg::REG_NX: nx <= cfg_data;
        tps_pkg::REG_NY: ny <= cfg_data;
        tps_pkg::REG_NZ: nz <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: capture the vertices, lanes multiply
  logic signed [CW-1:0] v [4][3];
  logic signed [SW-1:0] side [4];
  logic in_fire, s1_valid, busy_calc;
  logic [CntW-1:0] calc_cnt;
  logic emit_busy;
  logic load;
  logic calc_run;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v[0] <= '{v0_x, v0_y, v0_z};
      v[1] <= '{v1_x, v1_y, v1_z};
      v[2] <= '{v2_x, v2_y, v2_z};
      v[3] <= '{v3_x, v3_y, v3_z};
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_side
    tps_side_lane u_side (
      .clk(clk), .en(in_fire),
      .vx(i == 0 ? v0_x : i == 1 ? v1_x : i == 2 ? v2_x : v3_x),
      .vy(i == 0 ? v0_y : i == 1 ? v1_y : i == 2 ? v2_y : v3_y),
      .vz(i == 0 ? v0_z : i == 1 ? v1_z : i == 2 ? v2_z : v3_z),
      .px(px), .py(py), .pz(pz), .nx(nx), .ny(ny), .nz(nz),
      .side(side[i])
    );
  end

  // stage 1: classify, sort into lists, start the cut lanes
  logic [3:0] pos;
  logic [1:0] pix [4], nix [4];
  logic [2:0] pc_c;
  logic [SW-1:0] sd [4];
  always_comb begin
    logic [2:0] np, nn;
    np = '0; nn = '0;
    for (int i = 0; i < 4; i++) begin
      pix[i] = '0; nix[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      pos[i] = !side[i][SW-1] && (side[i] != '0);
      if (pos[i]) begin
        pix[np[1:0]] = 2'(i); np = np + 3'd1;
      end else begin
        nix[nn[1:0]] = 2'(i); nn = nn + 3'd1;
      end
      sd[i] = side[i];
    end
    pc_c = np;
  end

  assign calc_run = busy_calc && calc_cnt != CntW'(Lat - 1);

  logic signed [CW-1:0] cut [4][4][3];
  for (genvar p = 0; p < 4; p++) begin : g_p
    for (genvar n = 0; n < 4; n++) begin : g_n
      tps_cut_lane #(.FracBits(FracBits)) u_cut (
        .clk(clk), .start(s1_valid && !busy_calc), .run(calc_run),
        .num(sd[pix[p]]), .den(sd[pix[p]] - sd[nix[n]]),
        .ax(v[pix[p]][0]), .ay(v[pix[p]][1]), .az(v[pix[p]][2]),
        .bx(v[nix[n]][0]), .by(v[nix[n]][1]), .bz(v[nix[n]][2]),
        .cx(cut[p][n][0]), .cy(cut[p][n][1]), .cz(cut[p][n][2])
      );
    end
  end

  // held lists and cut points for the emission stage
  logic signed [CW-1:0] lst [8][3];
  logic signed [CW-1:0] lst_c [8][3];
  logic signed [CW-1:0] cut_h [4][4][3];
  logic [2:0] pc_r;
  always_comb begin
    for (int i = 0; i < 8; i++) lst_c[i] = '{default: '0};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < pc_c) lst_c[i] = v[pix[i]];
      if (3'(i) < 3'd4 - pc_c) lst_c[4 + i] = v[nix[i]];
    end
  end

  assign load = busy_calc && calc_cnt == CntW'(Lat - 1) && !emit_busy;
  assign in_ready = !s1_valid;

  // s1_valid: item held in stage 1; busy_calc: dividers iterating
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      busy_calc <= 1'b0;
      calc_cnt <= '0;
    end else begin
      if (in_fire) s1_valid <= 1'b1;
      if (s1_valid && !busy_calc) begin
        busy_calc <= 1'b1;
        calc_cnt <= '0;
      end else if (calc_run) begin
        calc_cnt <= calc_cnt + CntW'(1);
      end else if (load) begin
        busy_calc <= 1'b0;
        s1_valid <= 1'b0;
      end
    end
  end

  // the sequencer keeps its own copy so the next item can use the lanes
  always_ff @(posedge clk) begin
    if (load) begin
      lst <= lst_c;
      cut_h <= cut;
    end
  end

  // emission sequencer: piece row and corner counters
  logic [3:0] row;
  logic [2:0] pieces_left;
  logic [1:0] corner;
  tps_pkg::piece_row_t prow;
  logic [4:0] code;
  logic signed [CW-1:0] pt [3];

  assign prow = tps_pkg::piece_row(row);

  always_comb begin
    case (corner)
      2'd0: code = prow.p0;
      2'd1: code = prow.p1;
      2'd2: code = prow.p2;
      default: code = prow.p3;
    endcase
    if (code[4] || code[3]) begin
      pt = cut_h[2'(({1'b0, code} - 6'd8) >> 2)][code[1:0]];
    end else begin
      pt = lst[code[2:0]];
    end
  end

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      out_valid <= 1'b0;
      row <= '0; corner <= '0; pieces_left <= '0; pc_r <= '0;
    end else begin
      if (emit_busy && (!out_valid || out_fire)) begin
        out_valid <= 1'b1;
        out_x <= pt[0]; out_y <= pt[1]; out_z <= pt[2];
        piece_side <= prow.side;
        positive_count <= pc_r;
        piece_end <= corner == 2'd3;
        last <= corner == 2'd3 && pieces_left == 3'd1;
        corner <= corner + 2'd1;
        if (corner == 2'd3) begin
          row <= row + 4'd1;
          pieces_left <= pieces_left - 3'd1;
          if (pieces_left == 3'd1) emit_busy <= 1'b0;
        end
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        emit_busy <= 1'b1;
        row <= tps_pkg::case_start(pc_c);
        pieces_left <= tps_pkg::case_count(pc_c);
        pc_r <= pc_c;
        corner <= '0;
      end
    end
  end

  `include "tetra_plane_split_unit_assert.svh"
  `TPS_ASSERT(a_pc_range, !out_valid || positive_count <= 3'd4, "positive count out of range")
  `TPS_ASSERT(a_last_end, !out_valid || !last || piece_end, "last without piece end")
  `TPS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x), "beat dropped under stall")
endmodule
`default_nettype wire
